[rtl/lfpd_pkg.sv]
// Package: shared types, codes and constants of the length-framed packet deframer
`default_nettype none

package lfpd_pkg;

   localparam int NUM_TYPES_DEF = 96;

   localparam logic [15:0] HDR_BYTES   = 16'd3;
   localparam logic [7:0]  SYNC_TYPE   = 8'h20;
   localparam logic [7:0]  SYNC_MARKER = 8'h0E;
   localparam logic [31:0] NO_CMD      = 32'hFFFF_FFFF;

   localparam logic [5:0]  SYNC_OFFSET_RST = 6'd12;

   // input function codes
   localparam logic [1:0] FUNC_BYTE    = 2'd0;
   localparam logic [1:0] FUNC_CLOSE   = 2'd1;
   localparam logic [1:0] FUNC_CONNECT = 2'd2;

   // result status codes
   localparam logic [1:0] ST_BUSY   = 2'd0;
   localparam logic [1:0] ST_DONE   = 2'd1;
   localparam logic [1:0] ST_CLOSED = 2'd2;

   // sequence events
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_ADVANCE = 3'd1;
   localparam logic [2:0] EV_DUP     = 3'd2;
   localparam logic [2:0] EV_SYNC    = 3'd3;
   localparam logic [2:0] EV_LOST    = 3'd4;

   // register indexes
   localparam int          CSR_IDX_W       = 1;
   localparam logic [0:0]  CSR_LAST_SYNC   = 1'b0;
   localparam logic [0:0]  CSR_SYNC_OFFSET = 1'b1;
   localparam int          CSR_DATA_W      = 32;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  seq_event;
      logic [15:0] frame_length;
      logic [7:0]  frame_type;
      logic [31:0] frame_count;
      logic        stats_updated;
      logic [31:0] type_packet_total;
      logic [31:0] type_byte_total;
      logic [31:0] rx_byte_total;
   } rsp_item_type;

   // parsed item waiting for its counter read
   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  seq_event;
      logic [15:0] frame_length;
      logic [7:0]  frame_type;
      logic [31:0] frame_count;
      logic        stats_updated;
      logic [31:0] rx_byte_total;
   } stage_type;

   typedef struct packed {
      logic        en;
      logic [7:0]  type_idx;
      logic [15:0] frame_length;
   } stats_req_type;

endpackage

`default_nettype wire

[rtl/length_framed_packet_deframer.sv]
// Top level of the length-framed packet deframer
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  lfpd_pkg::req_item_type
//   rsp_      out         rsp_valid / rsp_stall  lfpd_pkg::rsp_item_type
//   csr_      in          csr_wr_en              csr_index, csr_wdata
//
// One item per cycle while req_stall is low, passing the parser stage, then
// output register. The counter memory is read as a completing item is accepted
// and written back as it enters the output register (one read, one write port).
// Synchronous reset; the counter store reads zero at once via per-entry valid
// bits, no clearing pass. A stalled result holds the parser stage; req_stall
// rises only when both stages are full and rsp_stall is high.
`default_nettype none

module length_framed_packet_deframer #(
   parameter int NUM_TYPES = lfpd_pkg::NUM_TYPES_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire lfpd_pkg::req_item_type                 req_item,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output lfpd_pkg::rsp_item_type                      rsp_item,
   input  wire logic                                   csr_wr_en,
   input  wire logic [lfpd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [lfpd_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   logic [31:0] last_sync_ff;
   logic [5:0]  sync_off_ff;

   logic                    accept;
   logic                    stage_valid;
   logic                    advance;
   lfpd_pkg::stage_type     stage;
   lfpd_pkg::stats_req_type stats_req;
   logic [31:0]             pkt_total;
   logic [31:0]             byte_total;

   logic                    out_vld_ff;
   lfpd_pkg::rsp_item_type  out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sync_ff <= '0;
         sync_off_ff  <= lfpd_pkg::SYNC_OFFSET_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            lfpd_pkg::CSR_LAST_SYNC:   last_sync_ff <= csr_wdata[31:0];
            lfpd_pkg::CSR_SYNC_OFFSET: sync_off_ff  <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   assign advance   = stage_valid && (!out_vld_ff || !rsp_stall);
   assign req_stall = stage_valid && !advance;
   assign accept    = req_valid && !req_stall;

   lfpd_frame_parser #(.NUM_TYPES(NUM_TYPES)) u_parser (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_item         (req_item),
      .advance          (advance),
      .last_sync_count  (last_sync_ff),
      .sync_byte_offset (sync_off_ff),
      .stage_valid      (stage_valid),
      .stage            (stage),
      .stats_req        (stats_req)
   );

   lfpd_type_stats #(.NUM_TYPES(NUM_TYPES)) u_stats (
      .clock             (clock),
      .reset             (reset),
      .stats_req         (stats_req),
      .commit            (advance && stage.stats_updated),
      .type_packet_total (pkt_total),
      .type_byte_total   (byte_total)
   );

   always_comb begin
      out_in.status            = stage.status;
      out_in.seq_event         = stage.seq_event;
      out_in.frame_length      = stage.frame_length;
      out_in.frame_type        = stage.frame_type;
      out_in.frame_count       = stage.frame_count;
      out_in.stats_updated     = stage.stats_updated;
      out_in.type_packet_total = stage.stats_updated ? pkt_total  : 32'd0;
      out_in.type_byte_total   = stage.stats_updated ? byte_total : 32'd0;
      out_in.rx_byte_total     = stage.rx_byte_total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_ff;

endmodule

`default_nettype wire

[rtl/lfpd_type_stats.sv]
// Per-type packet and byte counter memory with read-modify-write
`default_nettype none

module lfpd_type_stats #(
   parameter int NUM_TYPES = lfpd_pkg::NUM_TYPES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lfpd_pkg::stats_req_type stats_req,
   input  wire logic                   commit,
   output logic [31:0]                 type_packet_total,
   output logic [31:0]                 type_byte_total
);

   localparam int AW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

   logic [63:0]          mem [NUM_TYPES];
   logic [NUM_TYPES-1:0] vld_ff;
   logic [AW-1:0]        addr_ff;
   logic [15:0]          flen_ff;
   logic [63:0]          rd_ff;
   logic                 rd_vld_ff;
   logic [AW-1:0]        rd_addr;
   logic [31:0]          base_pkt;
   logic [31:0]          base_byte;

   assign rd_addr = stats_req.type_idx[AW-1:0];

   // read at the completing item's accept, write back when it leaves the stage;
   // completions are at least three items apart so the two never meet
   always_ff @(posedge clock) begin
      if (stats_req.en) begin
         rd_ff   <= mem[rd_addr];
         addr_ff <= rd_addr;
         flen_ff <= stats_req.frame_length;
      end
      if (commit) begin
         mem[addr_ff] <= {type_packet_total, type_byte_total};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (commit) begin
            vld_ff[addr_ff] <= 1'b1;
         end
         if (stats_req.en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign base_pkt          = rd_vld_ff ? rd_ff[63:32] : 32'd0;
   assign base_byte         = rd_vld_ff ? rd_ff[31:0]  : 32'd0;
   assign type_packet_total = base_pkt + 32'd1;
   assign type_byte_total   = base_byte + {16'd0, flen_ff};

endmodule

`default_nettype wire

[rtl/lfpd_frame_parser.sv]
// Frame parser: cursor, header and field capture, sequence check, first stage
`default_nettype none

module lfpd_frame_parser #(
   parameter int NUM_TYPES = lfpd_pkg::NUM_TYPES_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire lfpd_pkg::req_item_type  req_item,
   input  wire logic                    advance,
   input  wire logic [31:0]             last_sync_count,
   input  wire logic [5:0]              sync_byte_offset,
   output logic                         stage_valid,
   output lfpd_pkg::stage_type          stage,
   output lfpd_pkg::stats_req_type      stats_req
);

   logic [15:0] cursor_ff,   cursor_in;
   logic [15:0] flen_ff,     flen_in;
   logic [7:0]  type_ff,     type_in;
   logic [31:0] cmd_ff,      cmd_in;
   logic [31:0] count_ff,    count_in;
   logic [7:0]  syncb_ff,    syncb_in;
   logic [31:0] last_req_ff, last_req_in;
   logic        closed_ff,   closed_in;
   logic [31:0] total_ff,    total_in;
   logic        stage_vld_ff;
   lfpd_pkg::stage_type stage_ff, stage_in;

   logic [15:0] pos;
   logic [7:0]  b;
   logic [7:0]  cap_type;
   logic [15:0] cap_flen;
   logic [31:0] cap_cmd;
   logic [31:0] cap_cnt;
   logic [7:0]  cap_sync;
   logic [15:0] nc;
   logic        done;
   logic [2:0]  ev;
   logic [31:0] lr_next;
   logic        upd;

   always_comb begin
      pos = cursor_ff;
      b   = req_item.data_byte;

      cap_type = (pos == 16'd0) ? b : type_ff;
      cap_flen = flen_ff;
      if (pos == 16'd0) begin
         cap_flen = 16'd0;
      end else if (pos == 16'd1) begin
         cap_flen = {flen_ff[15:8], b};
      end else if (pos == 16'd2) begin
         cap_flen = {b, flen_ff[7:0]};
      end
      cap_cmd = (pos == 16'd0) ? 32'd0 : cmd_ff;
      cap_cnt = (pos == 16'd0) ? 32'd0 : count_ff;
      for (int k = 0; k < 4; k++) begin
         if (pos == 16'(4 + k)) begin
            cap_cmd[8*k +: 8] = cmd_ff[8*k +: 8] | b;
         end
         if (pos == 16'(8 + k)) begin
            cap_cnt[8*k +: 8] = count_ff[8*k +: 8] | b;
         end
      end
      if (pos == {10'd0, sync_byte_offset}) begin
         cap_sync = b;
      end else begin
         cap_sync = (pos == 16'd0) ? 8'd0 : syncb_ff;
      end

      nc   = pos + 16'd1;
      done = (nc >= lfpd_pkg::HDR_BYTES) &&
             ((nc == cap_flen) ||
              ((nc == lfpd_pkg::HDR_BYTES) && (cap_flen < lfpd_pkg::HDR_BYTES)));

      lr_next = last_req_ff;
      if (cap_cmd == lfpd_pkg::NO_CMD) begin
         ev = lfpd_pkg::EV_NONE;
      end else if (last_req_ff + 32'd1 == cap_cnt) begin
         ev      = lfpd_pkg::EV_ADVANCE;
         lr_next = cap_cnt;
      end else if (cap_cnt == last_sync_count) begin
         ev = lfpd_pkg::EV_DUP;
      end else if ((cap_type == lfpd_pkg::SYNC_TYPE) &&
                   (cap_sync == lfpd_pkg::SYNC_MARKER)) begin
         ev = lfpd_pkg::EV_SYNC;
      end else begin
         ev      = lfpd_pkg::EV_LOST;
         lr_next = cap_cnt;
      end

      upd = ({1'b0, cap_type} < 9'(NUM_TYPES)) && (nc > {8'd0, cap_type});
   end

   always_comb begin
      cursor_in   = cursor_ff;
      flen_in     = flen_ff;
      type_in     = type_ff;
      cmd_in      = cmd_ff;
      count_in    = count_ff;
      syncb_in    = syncb_ff;
      last_req_in = last_req_ff;
      closed_in   = closed_ff;
      total_in    = total_ff;
      stage_in        = '0;
      stage_in.status = closed_ff ? lfpd_pkg::ST_CLOSED : lfpd_pkg::ST_BUSY;
      stats_req       = '0;

      if (accept) begin
         case (req_item.func)
            lfpd_pkg::FUNC_CLOSE: begin
               closed_in       = 1'b1;
               stage_in.status = lfpd_pkg::ST_CLOSED;
            end
            lfpd_pkg::FUNC_CONNECT: begin
               closed_in       = 1'b0;
               cursor_in       = 16'd0;
               total_in        = 32'd0;
               stage_in.status = lfpd_pkg::ST_BUSY;
            end
            lfpd_pkg::FUNC_BYTE: begin
               if (!closed_ff) begin
                  type_in   = cap_type;
                  flen_in   = cap_flen;
                  cmd_in    = cap_cmd;
                  count_in  = cap_cnt;
                  syncb_in  = cap_sync;
                  total_in  = total_ff + 32'd1;
                  cursor_in = done ? 16'd0 : nc;
                  if (done) begin
                     last_req_in            = lr_next;
                     stage_in.status        = lfpd_pkg::ST_DONE;
                     stage_in.seq_event     = ev;
                     stage_in.frame_length  = nc;
                     stage_in.frame_type    = cap_type;
                     stage_in.frame_count   = cap_cnt;
                     stage_in.stats_updated = upd;
                     stats_req.en           = upd;
                     stats_req.type_idx     = cap_type;
                     stats_req.frame_length = nc;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      stage_in.rx_byte_total = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         flen_ff      <= '0;
         type_ff      <= '0;
         cmd_ff       <= '0;
         count_ff     <= '0;
         syncb_ff     <= '0;
         last_req_ff  <= '0;
         closed_ff    <= 1'b0;
         total_ff     <= '0;
         stage_vld_ff <= 1'b0;
      end else begin
         cursor_ff   <= cursor_in;
         flen_ff     <= flen_in;
         type_ff     <= type_in;
         cmd_ff      <= cmd_in;
         count_ff    <= count_in;
         syncb_ff    <= syncb_in;
         last_req_ff <= last_req_in;
         closed_ff   <= closed_in;
         total_ff    <= total_in;
         if (accept) begin
            stage_vld_ff <= 1'b1;
         end else if (advance) begin
            stage_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = stage_vld_ff;
   assign stage       = stage_ff;

endmodule

`default_nettype wire

[rtl/lfpd_checker.sv]
// Port-level checker for the deframer, bound to the top level
`default_nettype none

module lfpd_checker #(
   parameter int NUM_TYPES = lfpd_pkg::NUM_TYPES_DEF
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire lfpd_pkg::rsp_item_type           rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty output");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != lfpd_pkg::ST_DONE) |->
         (rsp_item.seq_event == lfpd_pkg::EV_NONE) && (rsp_item.frame_length == 16'd0) &&
         !rsp_item.stats_updated && (rsp_item.type_packet_total == 32'd0))
      else $error("frame fields set on an item that completes no frame");

   a_stats_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.stats_updated |->
         ({1'b0, rsp_item.frame_type} < 9'(NUM_TYPES)) &&
         (rsp_item.frame_length > {8'd0, rsp_item.frame_type}) &&
         (rsp_item.frame_length >= lfpd_pkg::HDR_BYTES) &&
         (rsp_item.type_packet_total != 32'd0))
      else $error("per-type counters updated against the rule");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind length_framed_packet_deframer lfpd_checker #(.NUM_TYPES(NUM_TYPES)) u_lfpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the length-framed packet deframer: random framed byte traffic
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         SHOW_MAX    = 100;

   // Tracks the deframer state and queues the result due for every accepted item
   class deframe_tracker;
      logic [31:0] last_sync;
      logic [5:0]  sync_off;
      logic [15:0] cursor;
      logic [15:0] len_field;
      logic [7:0]  ftype;
      logic [7:0]  sync_seen;
      logic [31:0] cmd_id;
      logic [31:0] count_field;
      logic [31:0] last_req;
      logic [31:0] rx_total;
      bit          closed;
      logic [31:0] pkt_count [lfpd_pkg::NUM_TYPES_DEF];
      logic [31:0] octet_count [lfpd_pkg::NUM_TYPES_DEF];
      lfpd_pkg::rsp_item_type results_due [$];
      int errors;
      int frames;
      int stat_hits;
      int closes;
      int connects;
      int ev_tally [5];

      function new();
         last_sync = '0;
         sync_off = lfpd_pkg::SYNC_OFFSET_RST;
         cursor = '0;
         len_field = '0;
         ftype = '0;
         sync_seen = '0;
         cmd_id = '0;
         count_field = '0;
         last_req = '0;
         rx_total = '0;
         closed = 1'b0;
         foreach (pkt_count[i]) begin
            pkt_count[i] = '0;
            octet_count[i] = '0;
         end
         foreach (ev_tally[i]) ev_tally[i] = 0;
         errors = 0;
         frames = 0;
         stat_hits = 0;
         closes = 0;
         connects = 0;
      endfunction

      function void set_reg(logic [lfpd_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
         if (idx == lfpd_pkg::CSR_LAST_SYNC) begin
            last_sync = val;
         end else begin
            sync_off = val[5:0];
         end
      endfunction

      function logic [2:0] sequence_event();
         if (cmd_id == lfpd_pkg::NO_CMD) return lfpd_pkg::EV_NONE;
         if (last_req + 32'd1 == count_field) begin
            last_req = count_field;
            return lfpd_pkg::EV_ADVANCE;
         end
         if (count_field == last_sync) return lfpd_pkg::EV_DUP;
         if (ftype == lfpd_pkg::SYNC_TYPE && sync_seen == lfpd_pkg::SYNC_MARKER)
            return lfpd_pkg::EV_SYNC;
         last_req = count_field;
         return lfpd_pkg::EV_LOST;
      endfunction

      function void take_item(lfpd_pkg::req_item_type it);
         lfpd_pkg::rsp_item_type r;
         logic [15:0]  pos;
         r = '0;
         r.status = closed ? lfpd_pkg::ST_CLOSED : lfpd_pkg::ST_BUSY;
         if (it.func == lfpd_pkg::FUNC_CLOSE) begin
            closed = 1'b1;
            r.status = lfpd_pkg::ST_CLOSED;
            closes++;
         end else if (it.func == lfpd_pkg::FUNC_CONNECT) begin
            closed = 1'b0;
            cursor = '0;
            rx_total = '0;
            r.status = lfpd_pkg::ST_BUSY;
            connects++;
         end else if (it.func == lfpd_pkg::FUNC_BYTE && !closed) begin
            pos = cursor;
            if (pos == 16'd0) begin
               ftype = it.data_byte;
               len_field = '0;
               cmd_id = '0;
               count_field = '0;
               sync_seen = '0;
            end else if (pos == 16'd1) begin
               len_field[7:0] = it.data_byte;
            end else if (pos == 16'd2) begin
               len_field[15:8] = it.data_byte;
            end
            if (pos >= 16'd4 && pos < 16'd8)
               cmd_id |= 32'(it.data_byte) << (8 * (pos - 16'd4));
            if (pos >= 16'd8 && pos < 16'd12)
               count_field |= 32'(it.data_byte) << (8 * (pos - 16'd8));
            if (pos == 16'(sync_off)) sync_seen = it.data_byte;
            cursor = cursor + 16'd1;
            rx_total = rx_total + 32'd1;
            if (cursor >= lfpd_pkg::HDR_BYTES && (cursor == len_field ||
                (cursor == lfpd_pkg::HDR_BYTES && len_field < lfpd_pkg::HDR_BYTES))) begin
               r.status = lfpd_pkg::ST_DONE;
               r.frame_length = cursor;
               r.frame_type = ftype;
               r.frame_count = count_field;
               r.seq_event = sequence_event();
               if (ftype < lfpd_pkg::NUM_TYPES_DEF && cursor > 16'(ftype)) begin
                  pkt_count[ftype] = pkt_count[ftype] + 32'd1;
                  octet_count[ftype] = octet_count[ftype] + 32'(cursor);
                  r.stats_updated = 1'b1;
                  r.type_packet_total = pkt_count[ftype];
                  r.type_byte_total = octet_count[ftype];
                  stat_hits++;
               end
               cursor = '0;
               frames++;
               ev_tally[r.seq_event]++;
            end
         end
         r.rx_byte_total = rx_total;
         results_due.push_back(r);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= SHOW_MAX)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(lfpd_pkg::rsp_item_type got);
         lfpd_pkg::rsp_item_type want;
         if (results_due.size() == 0) begin
            errors++;
            if (errors <= SHOW_MAX)
               $display("%0t: result with nothing expected, actual %p", $time, got);
            return;
         end
         want = results_due.pop_front();
         check_field("status", want.status, got.status);
         check_field("seq_event", want.seq_event, got.seq_event);
         check_field("frame_length", want.frame_length, got.frame_length);
         check_field("frame_type", want.frame_type, got.frame_type);
         check_field("frame_count", want.frame_count, got.frame_count);
         check_field("stats_updated", want.stats_updated, got.stats_updated);
         check_field("type_packet_total", want.type_packet_total, got.type_packet_total);
         check_field("type_byte_total", want.type_byte_total, got.type_byte_total);
         check_field("rx_byte_total", want.rx_byte_total, got.rx_byte_total);
      endfunction
   endclass

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   lfpd_pkg::req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   lfpd_pkg::rsp_item_type rsp_item;
   logic         csr_wr_en = 1'b0;
   logic [lfpd_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [lfpd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   deframe_tracker trk = new();
   int counted = 0;
   bit no_idle = 1'b0;
   int stall_mode = 1;

   length_framed_packet_deframer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   function automatic int pick_gap();
      if (no_idle) return 0;
      if ($urandom_range(0, 99) < 50) return 0;
      return idle_len();
   endfunction

   // result side back-pressure, in runs
   initial begin
      int  run_left;
      bit  level;
      run_left = 0;
      level = 1'b0;
      forever begin
         @(negedge clock);
         if (run_left == 0) begin
            level = (stall_mode != 0) &&
                    ($urandom_range(0, 99) < ((stall_mode == 2) ? 60 : 30));
            run_left = level ? idle_len() : $urandom_range(1, 8);
         end
         rsp_stall <= level;
         run_left--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) trk.check_result(rsp_item);
   end

   task automatic send(input logic [1:0] f, input logic [7:0] d, input int gap);
      lfpd_pkg::req_item_type it;
      it.func = f;
      it.data_byte = d;
      if (!(f == lfpd_pkg::FUNC_BYTE && trk.closed)) counted++;
      @(negedge clock);
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      trk.take_item(it);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic settle();
      if (req_valid) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      while (trk.results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lfpd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      trk.set_reg(idx, val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // one frame; a broken one gets a random length and is cut short by a connect,
   // optionally with a close and ignored bytes in between
   task automatic send_frame(input bit broken, input bit close_mid);
      logic [7:0]  fb [$];
      logic [7:0]  t;
      logic [15:0] flen;
      logic [31:0] cid;
      logic [31:0] cnt;
      bit          want_marker;
      int          n;
      int          r;
      int          cut;
      r = $urandom_range(0, 99);
      if (r < 20) t = lfpd_pkg::SYNC_TYPE;
      else if (r < 55) t = 8'($urandom_range(0, 40));
      else if (r < 80) t = 8'($urandom_range(0, 95));
      else t = 8'($urandom_range(96, 255));
      r = $urandom_range(0, 99);
      if (r < 8) flen = 16'($urandom_range(0, 2));
      else if (r < 75) flen = 16'($urandom_range(3, 24));
      else if (r < 95) flen = 16'($urandom_range(25, 70));
      else flen = 16'($urandom_range(100, 300));
      want_marker = (t == lfpd_pkg::SYNC_TYPE) && ($urandom_range(0, 4) != 0);
      if (want_marker && flen <= 16'(trk.sync_off))
         flen = 16'(trk.sync_off) + 16'd1 + 16'($urandom_range(0, 3));
      if (broken) flen = 16'($urandom_range(0, 65535));
      n = (flen < lfpd_pkg::HDR_BYTES) ? 3 : int'(flen);
      cid = ($urandom_range(0, 9) == 0) ? lfpd_pkg::NO_CMD : $urandom();
      r = $urandom_range(0, 99);
      if (r < 45) cnt = trk.last_req + 32'd1;
      else if (r < 60) cnt = trk.last_sync;
      else if (r < 70) cnt = trk.last_req;
      else if (r < 75) cnt = 32'hFFFF_FFFF;
      else cnt = $urandom();
      for (int i = 0; i < n && i < 320; i++) fb.push_back(8'($urandom_range(0, 255)));
      fb[0] = t;
      fb[1] = flen[7:0];
      fb[2] = flen[15:8];
      for (int k = 0; k < 4; k++) begin
         if (4 + k < fb.size()) fb[4 + k] = cid[8 * k +: 8];
         if (8 + k < fb.size()) fb[8 + k] = cnt[8 * k +: 8];
      end
      if (want_marker && trk.sync_off < fb.size()) fb[trk.sync_off] = lfpd_pkg::SYNC_MARKER;
      cut = broken ? $urandom_range(1, (n < 20) ? n - 1 : 20) : fb.size();
      for (int i = 0; i < cut; i++) send(lfpd_pkg::FUNC_BYTE, fb[i], pick_gap());
      if (broken) begin
         if (close_mid) begin
            send(lfpd_pkg::FUNC_CLOSE, 8'($urandom_range(0, 255)), pick_gap());
            repeat ($urandom_range(1, 5))
               send(lfpd_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)), pick_gap());
            if ($urandom_range(0, 1)) send(FUNC_UNUSED, 8'($urandom_range(0, 255)), pick_gap());
         end
         send(lfpd_pkg::FUNC_CONNECT, 8'($urandom_range(0, 255)), pick_gap());
      end
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(1, 6))
         send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), pick_gap());
      send(lfpd_pkg::FUNC_CONNECT, 8'($urandom_range(0, 255)), pick_gap());
   endtask

   initial begin
      logic [7:0]  opening [19];
      logic [31:0] ls;
      logic [5:0]  off;
      int          r;
      int          target;
      int          guard;
      // short frame, short frame of an uncounted type, then a sync frame
      opening = '{8'h00, 8'h00, 8'h00,
                  8'hFF, 8'h02, 8'h00,
                  8'h20, 8'h0D, 8'h00, 8'hFF, 8'h11, 8'h22, 8'h33, 8'h44,
                  8'h05, 8'h00, 8'h00, 8'h00, 8'h0E};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening[i]) send(lfpd_pkg::FUNC_BYTE, opening[i], pick_gap());
      send(lfpd_pkg::FUNC_CLOSE, 8'h00, pick_gap());
      send(lfpd_pkg::FUNC_BYTE, 8'hFF, pick_gap());
      send(FUNC_UNUSED, 8'hA5, pick_gap());
      send(lfpd_pkg::FUNC_BYTE, 8'h00, pick_gap());
      send(lfpd_pkg::FUNC_CONNECT, 8'h5A, pick_gap());

      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0: begin ls = 32'hFFFF_FFFF; off = 6'd63; end
            1: begin ls = 32'h0; off = 6'd3; end
            3: begin ls = trk.last_req + 32'd1; off = 6'($urandom_range(3, 63)); end
            4: begin ls = $urandom(); off = lfpd_pkg::SYNC_OFFSET_RST; end
            default: begin ls = $urandom(); off = 6'($urandom_range(3, 63)); end
         endcase
         write_reg(lfpd_pkg::CSR_LAST_SYNC, ls);
         write_reg(lfpd_pkg::CSR_SYNC_OFFSET, 32'(off));
         no_idle = (p == 1);
         stall_mode = (p == 1) ? 0 : ((p == 3) ? 2 : 1);
         target = counted + 72;
         while (counted < target) begin
            r = $urandom_range(0, 99);
            if (r < 82) send_frame(1'b0, 1'b0);
            else if (r < 89) send_frame(1'b1, 1'b0);
            else if (r < 94) send_frame(1'b1, 1'b1);
            else noise_burst();
         end
      end

      if (req_valid) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      guard = 0;
      while (trk.results_due.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (trk.results_due.size() != 0) begin
         trk.errors++;
         $display("%0t: %0d expected results never arrived", $time, trk.results_due.size());
      end
      $display("Sent %0d items, %0d frames done: advance %0d, dup %0d, sync %0d, lost %0d, %s %0d",
               counted, trk.frames, trk.ev_tally[lfpd_pkg::EV_ADVANCE],
               trk.ev_tally[lfpd_pkg::EV_DUP], trk.ev_tally[lfpd_pkg::EV_SYNC],
               trk.ev_tally[lfpd_pkg::EV_LOST], "none", trk.ev_tally[lfpd_pkg::EV_NONE]);
      $display("Per-type counter updates %0d, closes %0d, connects %0d, mismatches %0d",
               trk.stat_hits, trk.closes, trk.connects, trk.errors);
      if (trk.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
